// File: rtl/core/brbq_pkg.sv
// ----------------------------------------------------------------------------
// brbq_pkg
// Shared types and constants of the circular byte queue.
// ----------------------------------------------------------------------------
package brbq_pkg;

  localparam int CAP_W           = 11;
  localparam int BYTE_W          = 8;
  localparam int REQ_W           = 7;
  localparam int ADDR_W          = 3;
  localparam int STORE_DEPTH_DEF = 1024;
  localparam int MAX_GET_DEF     = 64;
  localparam int CAP_RESET       = 1024;

  localparam logic [ADDR_W-3:0] CFG_IDX_CAPACITY = '0;

  typedef enum logic {
    OP_PUSH = 1'b0,
    OP_GET  = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    KIND_ACK  = 2'd0,
    KIND_BYTE = 2'd1,
    KIND_NONE = 2'd2
  } kind_t;

  typedef struct packed {
    logic push;
    logic push_last;
    logic get_none;
    logic get_start;
    logic issue;
    logic emit;
    logic emit_last;
  } brbq_cmd_t;

  typedef struct packed {
    logic [CAP_W-1:0] queued;
    logic             out_free;
  } brbq_status_t;

endpackage

// File: rtl/core/brbq_datapath.sv
// ----------------------------------------------------------------------------
// brbq_datapath
// Byte store, ring indices, fill counters, capacity register and result
// register of the circular byte queue.
// ----------------------------------------------------------------------------
module brbq_datapath #(
  parameter int STORE_DEPTH    = brbq_pkg::STORE_DEPTH_DEF,
  parameter int MAX_GET_LENGTH = brbq_pkg::MAX_GET_DEF
) (
  input  logic                                     clk,
  input  logic                                     rst,
  input  brbq_pkg::brbq_cmd_t                      cmd,
  input  logic [$clog2(MAX_GET_LENGTH+1)-1:0]      xfer_len,
  input  logic [brbq_pkg::BYTE_W-1:0]              data_byte,
  input  logic                                     cfg_wr,
  input  logic [brbq_pkg::CAP_W-1:0]               cfg_data,
  output logic [brbq_pkg::CAP_W-1:0]               cap,
  output brbq_pkg::brbq_status_t                   status,
  input  logic                                     out_ready,
  output logic                                     out_valid,
  output brbq_pkg::kind_t                          out_kind,
  output logic [brbq_pkg::BYTE_W-1:0]              out_byte,
  output logic                                     out_last,
  output logic [brbq_pkg::CAP_W-1:0]               out_xfer,
  output logic [brbq_pkg::CAP_W-1:0]               out_queued
);
  import brbq_pkg::*;

  localparam int IDX_W     = $clog2(STORE_DEPTH);
  localparam int CMP_W     = (IDX_W + 1 > CAP_W) ? IDX_W + 1 : CAP_W;
  localparam int CAP_LIMIT = (STORE_DEPTH < 2047) ? STORE_DEPTH : 2047;
  localparam int CAP_INIT  = (CAP_RESET < CAP_LIMIT) ? CAP_RESET : CAP_LIMIT;
  localparam logic [CAP_W-1:0] CAP_MAX = CAP_W'(CAP_LIMIT);

  logic [BYTE_W-1:0] mem [STORE_DEPTH];
  logic [BYTE_W-1:0] mem_q;
  logic [IDX_W-1:0]  read_index;
  logic [IDX_W-1:0]  write_index;
  logic [CAP_W-1:0]  free_count;
  logic [CAP_W-1:0]  push_accepted;
  logic [CAP_W-1:0]  xfer;

  logic [CMP_W-1:0]  widx_inc;
  logic [CMP_W-1:0]  ridx_inc;
  logic [IDX_W-1:0]  widx_next;
  logic [IDX_W-1:0]  ridx_next;
  logic              room;
  logic [CAP_W-1:0]  free_push;
  logic [CAP_W-1:0]  free_emit;
  logic [CAP_W-1:0]  acc_push;
  logic [CAP_W-1:0]  cap_next;

  always_comb begin
    widx_inc  = CMP_W'(write_index) + CMP_W'(1);
    ridx_inc  = CMP_W'(read_index) + CMP_W'(1);
    widx_next = (widx_inc == CMP_W'(cap)) ? '0 : widx_inc[IDX_W-1:0];
    ridx_next = (ridx_inc == CMP_W'(cap)) ? '0 : ridx_inc[IDX_W-1:0];
    room      = (free_count != '0);
    free_push = room ? free_count - CAP_W'(1) : free_count;
    acc_push  = (room && push_accepted != '1) ? push_accepted + CAP_W'(1) : push_accepted;
    free_emit = free_count + CAP_W'(1);
    if (cfg_data == '0) begin
      cap_next = CAP_W'(1);
    end else if (cfg_data > CAP_MAX) begin
      cap_next = CAP_MAX;
    end else begin
      cap_next = cfg_data;
    end
    status.queued   = cap - free_count;
    status.out_free = !out_valid || out_ready;
  end

  always_ff @(posedge clk) begin
    if (cmd.push && room) begin
      mem[write_index] <= data_byte;
    end
    if (cmd.issue) begin
      mem_q <= mem[read_index];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cap           <= CAP_W'(CAP_INIT);
      read_index    <= '0;
      write_index   <= '0;
      free_count    <= CAP_W'(CAP_INIT);
      push_accepted <= '0;
      out_valid     <= 1'b0;
    end else if (cfg_wr) begin
      cap           <= cap_next;
      read_index    <= '0;
      write_index   <= '0;
      free_count    <= cap_next;
      push_accepted <= '0;
    end else begin
      if (cmd.push) begin
        if (room) begin
          write_index <= widx_next;
        end
        free_count    <= free_push;
        push_accepted <= cmd.push_last ? '0 : acc_push;
      end
      if (cmd.issue) begin
        read_index <= ridx_next;
      end
      if (cmd.emit) begin
        free_count <= free_emit;
      end
      if (cmd.emit || cmd.get_none || (cmd.push && cmd.push_last)) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.get_start) begin
      xfer <= CAP_W'(xfer_len);
    end
    if (cmd.push && cmd.push_last) begin
      out_kind   <= KIND_ACK;
      out_byte   <= '0;
      out_last   <= 1'b1;
      out_xfer   <= acc_push;
      out_queued <= cap - free_push;
    end else if (cmd.get_none) begin
      out_kind   <= KIND_NONE;
      out_byte   <= '0;
      out_last   <= 1'b1;
      out_xfer   <= '0;
      out_queued <= status.queued;
    end else if (cmd.emit) begin
      out_kind   <= KIND_BYTE;
      out_byte   <= mem_q;
      out_last   <= cmd.emit_last;
      out_xfer   <= xfer;
      out_queued <= cap - free_emit;
    end
  end

`ifndef ASSERT_OFF
  a_free_le_cap: assert property (@(posedge clk) disable iff (rst) free_count <= cap)
    else $error("free count exceeds capacity");
  a_ridx_in_ring: assert property (@(posedge clk) disable iff (rst)
    CMP_W'(read_index) < CMP_W'(cap))
    else $error("read index outside ring");
  a_widx_in_ring: assert property (@(posedge clk) disable iff (rst)
    CMP_W'(write_index) < CMP_W'(cap))
    else $error("write index outside ring");
  a_no_read_empty: assert property (@(posedge clk) disable iff (rst)
    cmd.issue |-> status.queued != '0)
    else $error("read issued on empty queue");
`endif

endmodule

// File: rtl/core/brbq_ctrl.sv
// ----------------------------------------------------------------------------
// brbq_ctrl
// Sequencer of the circular byte queue: accepts items, sizes get requests
// and paces store reads against the result register.
// ----------------------------------------------------------------------------
module brbq_ctrl #(
  parameter int MAX_GET_LENGTH = brbq_pkg::MAX_GET_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  brbq_pkg::op_t                       op,
  input  logic                                last_byte,
  input  logic [brbq_pkg::REQ_W-1:0]          request_length,
  input  brbq_pkg::brbq_status_t              status,
  output brbq_pkg::brbq_cmd_t                 cmd,
  output logic [$clog2(MAX_GET_LENGTH+1)-1:0] xfer_len
);
  import brbq_pkg::*;

  localparam int LEN_W = $clog2(MAX_GET_LENGTH + 1);
  localparam logic [REQ_W-1:0] REQ_MAX = REQ_W'(MAX_GET_LENGTH);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_GET  = 2'b10
  } state_t;

  state_t           state;
  state_t           state_next;
  logic [LEN_W-1:0] rd_left;
  logic [LEN_W-1:0] rd_left_next;
  logic [LEN_W-1:0] em_left;
  logic [LEN_W-1:0] em_left_next;
  logic             rd_pend;
  logic             rd_pend_next;
  logic             accept;
  logic [REQ_W-1:0] len_c;
  logic [CAP_W-1:0] len_w;
  logic [CAP_W-1:0] n_w;

  always_comb begin
    len_c    = (request_length > REQ_MAX) ? REQ_MAX : request_length;
    len_w    = CAP_W'(len_c);
    n_w      = (len_w < status.queued) ? len_w : status.queued;
    xfer_len = n_w[LEN_W-1:0];

    cmd          = '0;
    state_next   = state;
    rd_left_next = rd_left;
    em_left_next = em_left;
    rd_pend_next = rd_pend;
    in_ready     = 1'b0;
    accept       = 1'b0;

    unique case (state)
      ST_IDLE: begin
        in_ready = status.out_free;
        accept   = in_valid && in_ready;
        if (accept && op == OP_PUSH) begin
          cmd.push      = 1'b1;
          cmd.push_last = last_byte;
        end else if (accept) begin
          if (n_w == '0) begin
            cmd.get_none = 1'b1;
          end else begin
            cmd.get_start = 1'b1;
            cmd.issue     = 1'b1;
            rd_left_next  = xfer_len - LEN_W'(1);
            em_left_next  = xfer_len;
            rd_pend_next  = 1'b1;
            state_next    = ST_GET;
          end
        end
      end
      ST_GET: begin
        cmd.emit      = rd_pend && status.out_free;
        cmd.emit_last = (em_left == LEN_W'(1));
        cmd.issue     = (rd_left != '0) && (!rd_pend || cmd.emit);
        rd_pend_next  = cmd.issue || (rd_pend && !cmd.emit);
        if (cmd.issue) begin
          rd_left_next = rd_left - LEN_W'(1);
        end
        if (cmd.emit) begin
          em_left_next = em_left - LEN_W'(1);
          if (cmd.emit_last) begin
            state_next = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      rd_left <= '0;
      em_left <= '0;
      rd_pend <= 1'b0;
    end else begin
      state   <= state_next;
      rd_left <= rd_left_next;
      em_left <= em_left_next;
      rd_pend <= rd_pend_next;
    end
  end

`ifndef ASSERT_OFF
  a_get_has_work: assert property (@(posedge clk) disable iff (rst)
    state == ST_GET |-> em_left != '0)
    else $error("get sequence with nothing left to send");
  a_reads_lead: assert property (@(posedge clk) disable iff (rst)
    state == ST_GET |-> rd_left < em_left)
    else $error("read count not ahead of send count");
`endif

endmodule

// File: rtl/core/byte_ring_buffer_queue.sv
// ----------------------------------------------------------------------------
// byte_ring_buffer_queue
// Circular byte queue with a programmable usable capacity.
// ----------------------------------------------------------------------------
// Channel   Direction  Content
// s_axis    in         tuser operation, tlast last_byte, tdata data_byte/request_length
// m_axis    out        tuser result_kind, tlast last_result,
//                      tdata out_byte/transfer_count/queued_bytes
// apb       in/out     capacity_in_use at byte address 0
//
// A get that grants bytes first reads the store. The
// store read is registered, and after the first read one byte leaves per cycle while the output is not stalled.
// A get that grants no bytes, like a final push byte, yields a single result.
// Input is taken while no get is being sent and the result register is empty or being drained.
// Reset and a capacity write empty the queue; the store itself is not cleared.
// ----------------------------------------------------------------------------
module byte_ring_buffer_queue #(
  parameter int STORE_DEPTH    = brbq_pkg::STORE_DEPTH_DEF,
  parameter int MAX_GET_LENGTH = brbq_pkg::MAX_GET_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [15:0]                 s_axis_tdata,  // data_byte, request_length
  input  logic                        s_axis_tuser,  // operation
  input  logic                        s_axis_tlast,
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  output logic [31:0]                 m_axis_tdata,  // out_byte, transfer_count, queued_bytes
  output logic [1:0]                  m_axis_tuser,  // result_kind
  output logic                        m_axis_tlast,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [brbq_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);
  import brbq_pkg::*;

  localparam int LEN_W = $clog2(MAX_GET_LENGTH + 1);

  brbq_cmd_t         cmd;
  brbq_status_t      status;
  logic [LEN_W-1:0]  xfer_len;
  logic [CAP_W-1:0]  cap;
  logic              cfg_sel;
  logic              cfg_wr;
  kind_t             out_kind;
  logic [BYTE_W-1:0] out_byte;
  logic [CAP_W-1:0]  out_xfer;
  logic [CAP_W-1:0]  out_queued;

  assign pready  = 1'b1;
  assign cfg_sel = (paddr[ADDR_W-1:2] == CFG_IDX_CAPACITY);
  assign cfg_wr  = psel && penable && pwrite && pready && cfg_sel;
  assign prdata  = cfg_sel ? {{(32 - CAP_W){1'b0}}, cap} : '0;

  assign m_axis_tuser = out_kind;
  assign m_axis_tdata = {{(32 - BYTE_W - 2 * CAP_W){1'b0}}, out_queued, out_xfer, out_byte};

  brbq_ctrl #(
    .MAX_GET_LENGTH(MAX_GET_LENGTH)
  ) u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (s_axis_tvalid),
    .in_ready      (s_axis_tready),
    .op            (op_t'(s_axis_tuser)),
    .last_byte     (s_axis_tlast),
    .request_length(s_axis_tdata[BYTE_W +: REQ_W]),
    .status        (status),
    .cmd           (cmd),
    .xfer_len      (xfer_len)
  );

  brbq_datapath #(
    .STORE_DEPTH   (STORE_DEPTH),
    .MAX_GET_LENGTH(MAX_GET_LENGTH)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .xfer_len  (xfer_len),
    .data_byte (s_axis_tdata[BYTE_W-1:0]),
    .cfg_wr    (cfg_wr),
    .cfg_data  (pwdata[CAP_W-1:0]),
    .cap       (cap),
    .status    (status),
    .out_ready (m_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_kind  (out_kind),
    .out_byte  (out_byte),
    .out_last  (m_axis_tlast),
    .out_xfer  (out_xfer),
    .out_queued(out_queued)
  );

endmodule

// File: tb/byte_ring_buffer_queue_tb.sv
// ----------------------------------------------------------------------------
// byte_ring_buffer_queue_tb
// Self-checking testbench for the circular byte queue. A behavioral copy of
// the queue predicts every result of each accepted item, and each result
// taken from the output stream is compared field by field with the oldest
// prediction. Directed tests cover empty, zero-length and long gets, gets
// inside a push buffer, full-queue drops, index wrap and capacity clamping;
// random traffic runs under three stall patterns.
// ----------------------------------------------------------------------------
module byte_ring_buffer_queue_tb;
  import brbq_pkg::*;

  localparam int STORE_DEPTH    = STORE_DEPTH_DEF;
  localparam int MAX_GET_LENGTH = MAX_GET_DEF;
  localparam int COUNT_LIMIT    = (1 << CAP_W) - 1;
  localparam int SETTLE_CYCLES  = 4;
  localparam int STALL_LIMIT    = 2000;

  localparam logic [ADDR_W-1:0] CAPACITY_ADDR = {CFG_IDX_CAPACITY, 2'b00};
  localparam logic [ADDR_W-1:0] SPARE_ADDR    = {~CFG_IDX_CAPACITY, 2'b00};

  typedef struct packed {
    kind_t            kind;
    logic [7:0]       data;
    logic             last;
    logic [CAP_W-1:0] xfer;
    logic [CAP_W-1:0] queued;
  } result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata = '0;   // data_byte [7:0], request_length [14:8]
  logic        s_axis_tuser = 1'b0; // operation
  logic        s_axis_tlast = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;        // out_byte [7:0], transfer_count [18:8],
                                    // queued_bytes [29:19]
  logic [1:0]  m_axis_tuser;        // result_kind
  logic        m_axis_tlast;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [31:0]       pwdata = '0;
  logic [31:0]       prdata;
  logic              pready;

  byte_ring_buffer_queue DUT (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .s_axis_tlast(s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
    .m_axis_tlast(m_axis_tlast),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  logic [7:0] ring_store [STORE_DEPTH];
  int ring_cap = CAP_RESET;
  int head_idx = 0;
  int tail_idx = 0;
  int free_bytes = CAP_RESET;
  int run_accepted = 0;
  result_t expected_results [$];

  int error_count = 0;
  int items_sent = 0;
  int sender_idle_pct = 0;
  int receiver_idle_pct = 0;
  int stall_cycles = 0;

  task automatic report_error(input string msg);
    $display("ERROR: %s", msg);
    error_count++;
  endtask

  function automatic void apply_capacity(input logic [31:0] value);
    int c;
    c = value & 32'h7FF;
    if (c == 0) c = 1;
    if (c > STORE_DEPTH) c = STORE_DEPTH;
    ring_cap = c;
    head_idx = 0;
    tail_idx = 0;
    free_bytes = c;
    run_accepted = 0;
  endfunction

  function automatic void predict_push(input logic [7:0] data, input logic last);
    result_t r;
    if (free_bytes > 0) begin
      if (tail_idx >= ring_cap) tail_idx = 0;
      ring_store[tail_idx] = data;
      tail_idx = (tail_idx + 1) % ring_cap;
      free_bytes--;
      if (run_accepted < COUNT_LIMIT) run_accepted++;
    end
    if (last) begin
      r.kind = KIND_ACK;
      r.data = '0;
      r.last = 1'b1;
      r.xfer = CAP_W'(run_accepted);
      r.queued = CAP_W'(ring_cap - free_bytes);
      expected_results.push_back(r);
      run_accepted = 0;
    end
  endfunction

  function automatic void predict_get(input logic [6:0] req);
    result_t r;
    int len, held, n;
    len = (req > MAX_GET_LENGTH) ? MAX_GET_LENGTH : req;
    held = ring_cap - free_bytes;
    if (held == 0 || len == 0) begin
      r.kind = KIND_NONE;
      r.data = '0;
      r.last = 1'b1;
      r.xfer = '0;
      r.queued = CAP_W'(held);
      expected_results.push_back(r);
      return;
    end
    n = (len < held) ? len : held;
    for (int i = 0; i < n; i++) begin
      if (head_idx >= ring_cap) head_idx = 0;
      r.kind = KIND_BYTE;
      r.data = ring_store[head_idx];
      head_idx = (head_idx + 1) % ring_cap;
      free_bytes++;
      r.last = (i + 1 == n);
      r.xfer = CAP_W'(n);
      r.queued = CAP_W'(ring_cap - free_bytes);
      expected_results.push_back(r);
    end
  endfunction

  always @(posedge clk) begin
    m_axis_tready <= ($urandom_range(99) >= receiver_idle_pct);
  end

  always @(posedge clk) begin
    result_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (expected_results.size() == 0) begin
        report_error($sformatf("result with nothing expected, kind %0d", m_axis_tuser));
      end else begin
        want = expected_results.pop_front();
        if (m_axis_tuser != want.kind)
          report_error($sformatf("result_kind got %0d expected %0d", m_axis_tuser, want.kind));
        if (m_axis_tdata[7:0] != want.data)
          report_error($sformatf("out_byte got %0h expected %0h", m_axis_tdata[7:0], want.data));
        if (m_axis_tlast != want.last)
          report_error($sformatf("last_result got %0d expected %0d", m_axis_tlast, want.last));
        if (m_axis_tdata[18:8] != want.xfer)
          report_error($sformatf("transfer_count got %0d expected %0d",
                                 m_axis_tdata[18:8], want.xfer));
        if (m_axis_tdata[29:19] != want.queued)
          report_error($sformatf("queued_bytes got %0d expected %0d",
                                 m_axis_tdata[29:19], want.queued));
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (psel && penable && pwrite && pready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic send_item(input op_t op, input logic [7:0] data, input logic last,
                           input logic [6:0] len);
    while ($urandom_range(99) < sender_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= op;
    s_axis_tlast <= last;
    s_axis_tdata <= {1'b0, len, data};
    do @(posedge clk); while (!s_axis_tready);
    if (op == OP_PUSH) predict_push(data, last);
    else predict_get(len);
    items_sent++;
  endtask

  task automatic drain_results;
    s_axis_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(input logic [ADDR_W-1:0] addr, input logic [31:0] value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (addr[ADDR_W-1:2] == CFG_IDX_CAPACITY) apply_capacity(value);
  endtask

  task automatic test_basic_traffic;
    send_item(OP_GET, 8'h00, 1'b1, 7'd5);
    send_item(OP_GET, 8'hFF, 1'b0, 7'd0);
    send_item(OP_PUSH, 8'h00, 1'b0, 7'd0);
    send_item(OP_PUSH, 8'hFF, 1'b0, 7'd127);
    send_item(OP_PUSH, 8'h5A, 1'b1, 7'd0);
    send_item(OP_GET, 8'h00, 1'b0, 7'd0);
    send_item(OP_GET, 8'h00, 1'b0, 7'd127);
    send_item(OP_PUSH, 8'h11, 1'b0, 7'd0);
    send_item(OP_PUSH, 8'h22, 1'b0, 7'd0);
    send_item(OP_GET, 8'h00, 1'b0, 7'd1);
    send_item(OP_PUSH, 8'h33, 1'b1, 7'd0);
    send_item(OP_GET, 8'h00, 1'b1, 7'd64);
  endtask

  task automatic test_capacity_limits;
    drain_results;
    write_register(CAPACITY_ADDR, 32'd0);
    send_item(OP_PUSH, 8'hAB, 1'b0, 7'd0);
    send_item(OP_PUSH, 8'hCD, 1'b1, 7'd0);
    send_item(OP_GET, 8'h00, 1'b0, 7'd2);
    drain_results;
    write_register(SPARE_ADDR, 32'd5);
    send_item(OP_PUSH, 8'h01, 1'b1, 7'd0);
    send_item(OP_GET, 8'h00, 1'b0, 7'd1);
    drain_results;
    write_register(CAPACITY_ADDR, 32'd3);
    send_item(OP_PUSH, 8'hA1, 1'b0, 7'd0);
    send_item(OP_PUSH, 8'hA2, 1'b0, 7'd0);
    send_item(OP_PUSH, 8'hA3, 1'b1, 7'd0);
    send_item(OP_GET, 8'h00, 1'b0, 7'd2);
    send_item(OP_PUSH, 8'hA4, 1'b0, 7'd0);
    send_item(OP_PUSH, 8'hA5, 1'b1, 7'd0);
    send_item(OP_GET, 8'h00, 1'b0, 7'd5);
    send_item(OP_PUSH, 8'h77, 1'b0, 7'd0);
    drain_results;
    write_register(CAPACITY_ADDR, 32'd2047);
    send_item(OP_GET, 8'h00, 1'b0, 7'd1);
    send_item(OP_PUSH, 8'h99, 1'b1, 7'd0);
    send_item(OP_GET, 8'h00, 1'b0, 7'd1);
  endtask

  task automatic test_random_traffic(input int cap_value, input int item_goal,
                                     input int send_pct, input int recv_pct);
    int first, len;
    logic paused;
    drain_results;
    sender_idle_pct = send_pct;
    receiver_idle_pct = recv_pct;
    write_register(CAPACITY_ADDR, cap_value);
    first = items_sent;
    paused = 1'b0;
    while (items_sent - first < item_goal) begin
      if (!paused && items_sent - first >= item_goal / 2) begin
        paused = 1'b1;
        drain_results;
      end
      if ($urandom_range(99) < 55) begin
        len = $urandom_range(1, 12);
        for (int i = 0; i < len; i++)
          send_item(OP_PUSH, 8'($urandom_range(255)), i == len - 1,
                    7'($urandom_range(127)));
      end else if ($urandom_range(99) < 80) begin
        send_item(OP_GET, 8'($urandom_range(255)), 1'($urandom_range(1)),
                  7'($urandom_range(1, 64)));
      end else begin
        send_item(OP_GET, 8'($urandom_range(255)), 1'($urandom_range(1)),
                  7'($urandom_range(127)));
      end
    end
    for (int i = 0; i < 3; i++)
      send_item(OP_PUSH, 8'($urandom_range(255)), 1'b0, 7'($urandom_range(127)));
  endtask

  initial begin
    apply_capacity(CAP_RESET);
    sender_idle_pct = 15;
    receiver_idle_pct = 81;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    test_basic_traffic;
    test_capacity_limits;
    test_random_traffic($urandom_range(2, 40), 100, 15, 81);
    test_random_traffic(STORE_DEPTH, 100, 81, 15);
    test_random_traffic($urandom_range(1, 24), 100, 0, 0);
    drain_results;
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// File: byte_ring_buffer_queue.f
rtl/core/brbq_pkg.sv
rtl/core/brbq_datapath.sv
rtl/core/brbq_ctrl.sv
rtl/core/byte_ring_buffer_queue.sv
tb/byte_ring_buffer_queue_tb.sv
